// ===== rtl/core/stlr_pkg.sv =====
// Shared types, constants and constant lookups for the shuffled triple-LCG generator.
package stlr_pkg;

    // Shuffle table geometry
    localparam int TABLE_DEPTH = 97;
    localparam int TAB_AW      = $clog2(TABLE_DEPTH);

    // Generator constants (modulus, multiplier, increment)
    localparam logic [17:0] M_ONE   = 18'd259100;
    localparam logic [17:0] A_ONE   = 18'd7141;
    localparam logic [17:0] C_ONE   = 18'd54773;
    localparam logic [17:0] M_TWO   = 18'd134456;
    localparam logic [17:0] A_TWO   = 18'd8121;
    localparam logic [17:0] C_TWO   = 18'd28411;
    localparam logic [17:0] M_THREE = 18'd243000;
    localparam logic [17:0] A_THREE = 18'd4561;
    localparam logic [17:0] C_THREE = 18'd51349;

    // Reciprocals for quotient estimates: floor(2^RECIP_SHIFT / m)
    localparam int          RECIP_SHIFT = 48;
    localparam logic [30:0] RECIP_ONE   = 31'((64'd1 << RECIP_SHIFT) / 64'(M_ONE));
    localparam logic [30:0] RECIP_TWO   = 31'((64'd1 << RECIP_SHIFT) / 64'(M_TWO));
    localparam logic [30:0] RECIP_THREE = 31'((64'd1 << RECIP_SHIFT) / 64'(M_THREE));

    // Seed reduction: bias keeps 54773 - seed positive, as a multiple of M_ONE
    localparam int          SEED_BIAS_MULT = 8289;
    localparam logic [32:0] SEED_OFFSET    =
        33'(64'(C_ONE) + 64'(M_ONE) * 64'(SEED_BIAS_MULT));
    localparam int          RED_STEPS      = 15;
    localparam int          RED_SW         = $clog2(RED_STEPS);

    // Latency of a generator lane and of the slot unit
    localparam int LANE_LAT = 4;

    typedef enum logic [1:0] {
        GEN_ONE,
        GEN_TWO,
        GEN_THREE
    } t_gen;

    typedef struct packed {
        logic signed [31:0] seed;
    } t_seed_beat;

    typedef struct packed {
        logic [17:0]        draw_high;
        logic [17:0]        draw_low;
        logic signed [31:0] seed_out;
    } t_draw_beat;

    // Controller to datapath commands
    typedef struct packed {
        logic                  take_seed;
        logic                  seed_red;
        logic [RED_SW-1:0]     red_shift;
        logic                  load_gen1;
        logic                  step_one;
        logic                  step_two;
        logic                  step_three;
        logic                  two_from_one;
        logic                  three_from_one;
        logic                  fill_we;
        logic [TAB_AW-1:0]     fill_addr;
        logic                  read_slot;
        logic                  deliver;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic seed_neg;
    } t_sts;

    function automatic logic [17:0] gen_mod(input t_gen g);
        logic [17:0] v;
        unique case (g)
            GEN_ONE:   v = M_ONE;
            GEN_TWO:   v = M_TWO;
            GEN_THREE: v = M_THREE;
            default:   v = M_ONE;
        endcase
        return v;
    endfunction

    function automatic logic [17:0] gen_mul(input t_gen g);
        logic [17:0] v;
        unique case (g)
            GEN_ONE:   v = A_ONE;
            GEN_TWO:   v = A_TWO;
            GEN_THREE: v = A_THREE;
            default:   v = A_ONE;
        endcase
        return v;
    endfunction

    function automatic logic [17:0] gen_inc(input t_gen g);
        logic [17:0] v;
        unique case (g)
            GEN_ONE:   v = C_ONE;
            GEN_TWO:   v = C_TWO;
            GEN_THREE: v = C_THREE;
            default:   v = C_ONE;
        endcase
        return v;
    endfunction

    function automatic logic [30:0] gen_recip(input t_gen g);
        logic [30:0] v;
        unique case (g)
            GEN_ONE:   v = RECIP_ONE;
            GEN_TWO:   v = RECIP_TWO;
            GEN_THREE: v = RECIP_THREE;
            default:   v = RECIP_ONE;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/stlr_stream_if.sv =====
// Valid/ready stream interface carrying one payload beat.
interface stlr_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/stlr_lcg.sv =====
// Four-stage LCG step lane: (a*x + c) mod m by reciprocal quotient and one correction.
module stlr_lcg (
    input  logic            i_clk,
    input  stlr_pkg::t_gen  i_gen,
    input  logic [17:0]     i_x,
    output logic [17:0]     o_next
);

    logic [17:0] w_mod;
    logic [17:0] w_mul;
    logic [17:0] w_inc;
    logic [30:0] w_recip;
    logic [61:0] w_qprod;

    logic [30:0] r_prod;
    logic [30:0] r_prod_d;
    logic [13:0] r_quo;
    logic [18:0] r_diff;
    logic [17:0] r_res;

    assign w_mod   = stlr_pkg::gen_mod(i_gen);
    assign w_mul   = stlr_pkg::gen_mul(i_gen);
    assign w_inc   = stlr_pkg::gen_inc(i_gen);
    assign w_recip = stlr_pkg::gen_recip(i_gen);
    assign w_qprod = 62'(r_prod) * 62'(w_recip);

    // run the pipeline every cycle; the controller waits out its latency
    always_ff @(posedge i_clk) begin
        r_prod   <= 31'(31'(i_x) * 31'(w_mul)) + 31'(w_inc);
        r_quo    <= w_qprod[stlr_pkg::RECIP_SHIFT +: 14];
        r_prod_d <= r_prod;
        r_diff   <= 19'(r_prod_d - 31'(31'(r_quo) * 31'(w_mod)));
        r_res    <= (r_diff >= 19'(w_mod)) ? 18'(r_diff - 19'(w_mod)) : r_diff[17:0];
    end

    assign o_next = r_res;

endmodule

// ===== rtl/core/stlr_slot.sv =====
// Four-stage slot unit: floor(TABLE_DEPTH * g3 / M_THREE), clamped to the table.
module stlr_slot (
    input  logic                        i_clk,
    input  logic [17:0]                 i_g3,
    output logic [stlr_pkg::TAB_AW-1:0] o_slot
);

    localparam int VW = 25;

    logic [55:0]                 w_qprod;
    logic [stlr_pkg::TAB_AW:0]   w_sum;

    logic [VW-1:0]               r_v;
    logic [VW-1:0]               r_v_d;
    logic [stlr_pkg::TAB_AW-1:0] r_q;
    logic [stlr_pkg::TAB_AW-1:0] r_q_d;
    logic [18:0]                 r_t;
    logic [stlr_pkg::TAB_AW-1:0] r_slot;

    assign w_qprod = 56'(r_v) * 56'(stlr_pkg::RECIP_THREE);
    assign w_sum   = (stlr_pkg::TAB_AW + 1)'(r_q_d)
                   + (stlr_pkg::TAB_AW + 1)'(r_t >= 19'(stlr_pkg::M_THREE));

    // scale, estimate quotient, take remainder, correct and clamp
    always_ff @(posedge i_clk) begin
        r_v    <= VW'(VW'(i_g3) * VW'(stlr_pkg::TABLE_DEPTH));
        r_q    <= w_qprod[stlr_pkg::RECIP_SHIFT +: stlr_pkg::TAB_AW];
        r_v_d  <= r_v;
        r_q_d  <= r_q;
        r_t    <= 19'(r_v_d - VW'(VW'(r_q) * VW'(stlr_pkg::M_THREE)));
        r_slot <= (w_sum > (stlr_pkg::TAB_AW + 1)'(stlr_pkg::TABLE_DEPTH - 1))
                ? stlr_pkg::TAB_AW'(stlr_pkg::TABLE_DEPTH - 1)
                : w_sum[stlr_pkg::TAB_AW-1:0];
    end

    assign o_slot = r_slot;

endmodule

// ===== rtl/core/stlr_datapath.sv =====
// Datapath: generator registers, lanes, seed reduction, slot unit, shuffle table, result.
module stlr_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  stlr_pkg::t_cmd       i_cmd,
    output stlr_pkg::t_sts       o_sts,
    input  stlr_pkg::t_seed_beat i_seed,
    output stlr_pkg::t_draw_beat o_draw
);

    logic [17:0]                 r_gen1;
    logic [17:0]                 r_gen2;
    logic [17:0]                 r_gen3;
    logic                        r_seed_neg;
    logic signed [31:0]          r_seed_back;
    logic [32:0]                 r_red;
    logic [35:0]                 r_table [stlr_pkg::TABLE_DEPTH];
    logic [35:0]                 r_rd;
    stlr_pkg::t_draw_beat        r_draw;

    logic [17:0]                 w_next1;
    logic [17:0]                 w_next2;
    logic [17:0]                 w_next3;
    logic [stlr_pkg::TAB_AW-1:0] w_slot;
    logic [32:0]                 w_biased;
    logic [32:0]                 w_sub;
    logic                        w_we;
    logic [stlr_pkg::TAB_AW-1:0] w_waddr;
    logic [35:0]                 w_wdata;

    stlr_lcg u_lane_one (
        .i_clk  (i_clk),
        .i_gen  (stlr_pkg::GEN_ONE),
        .i_x    (r_gen1),
        .o_next (w_next1)
    );

    stlr_lcg u_lane_two (
        .i_clk  (i_clk),
        .i_gen  (stlr_pkg::GEN_TWO),
        .i_x    (r_gen2),
        .o_next (w_next2)
    );

    stlr_lcg u_lane_three (
        .i_clk  (i_clk),
        .i_gen  (stlr_pkg::GEN_THREE),
        .i_x    (r_gen3),
        .o_next (w_next3)
    );

    stlr_slot u_slot (
        .i_clk  (i_clk),
        .i_g3   (r_gen3),
        .o_slot (w_slot)
    );

    // bias the seed so the floor modulo becomes a plain unsigned reduction
    assign w_biased = stlr_pkg::SEED_OFFSET - 33'(i_seed.seed);
    assign w_sub    = 33'(stlr_pkg::M_ONE) << i_cmd.red_shift;

    // capture the seed and reduce it one shifted modulus per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_seed) begin
            r_red       <= w_biased;
            r_seed_neg  <= i_seed.seed[31];
            r_seed_back <= i_seed.seed;
        end else begin
            if (i_cmd.seed_red && (r_red >= w_sub)) begin
                r_red <= r_red - w_sub;
            end
            if (i_cmd.load_gen1) begin
                r_seed_back <= 32'sd1;
            end
        end
    end

    // advance the generators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen1 <= '0;
            r_gen2 <= '0;
            r_gen3 <= '0;
        end else begin
            if (i_cmd.load_gen1) begin
                r_gen1 <= r_red[17:0];
            end else if (i_cmd.step_one) begin
                r_gen1 <= w_next1;
            end
            if (i_cmd.two_from_one) begin
                r_gen2 <= (w_next1 >= stlr_pkg::M_TWO) ? w_next1 - stlr_pkg::M_TWO : w_next1;
            end else if (i_cmd.step_two) begin
                r_gen2 <= w_next2;
            end
            if (i_cmd.three_from_one) begin
                r_gen3 <= (w_next1 >= stlr_pkg::M_THREE) ? w_next1 - stlr_pkg::M_THREE
                                                         : w_next1;
            end else if (i_cmd.step_three) begin
                r_gen3 <= w_next3;
            end
        end
    end

    // fill writes the freshly stepped pair; a draw refills its slot
    assign w_we    = i_cmd.fill_we || i_cmd.deliver;
    assign w_waddr = i_cmd.fill_we ? i_cmd.fill_addr : w_slot;
    assign w_wdata = i_cmd.fill_we ? {w_next1, w_next2} : {r_gen1, r_gen2};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_table[w_waddr] <= w_wdata;
        end
        if (i_cmd.read_slot) begin
            r_rd <= r_table[w_slot];
        end
    end

    // load the result beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.deliver) begin
            r_draw.draw_high <= r_rd[35:18];
            r_draw.draw_low  <= r_rd[17:0];
            r_draw.seed_out  <= r_seed_back;
        end
    end

    assign o_sts.seed_neg = r_seed_neg;
    assign o_draw         = r_draw;

endmodule

// ===== rtl/core/stlr_ctrl.sv =====
// Controller: sequences seed reduction, table fill, draw, slot read and result hand-off.
module stlr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  stlr_pkg::t_sts i_sts,
    output stlr_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_REDUCE,
        ST_LOAD,
        ST_WAIT,
        ST_INIT_A,
        ST_INIT_B,
        ST_FILL,
        ST_DRAW,
        ST_READ,
        ST_DELIVER
    } t_state;

    localparam int CW = (stlr_pkg::RED_SW > 2) ? stlr_pkg::RED_SW : 2;

    t_state                      r_state, n_state;
    t_state                      r_ret, n_ret;
    logic [CW-1:0]               r_cnt, n_cnt;
    logic [stlr_pkg::TAB_AW-1:0] r_fill, n_fill;
    logic                        r_seeded, n_seeded;
    logic                        r_out_valid, n_out_valid;
    logic                        w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_cnt       = r_cnt;
        n_fill      = r_fill;
        n_seeded    = r_seeded;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.red_shift = stlr_pkg::RED_SW'(r_cnt);
        o_cmd.fill_addr = r_fill;
        o_in_ready  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take_seed = 1'b1;
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (i_sts.seed_neg || !r_seeded) begin
                    n_cnt   = CW'(stlr_pkg::RED_STEPS - 1);
                    n_state = ST_REDUCE;
                end else begin
                    n_cnt   = CW'(stlr_pkg::LANE_LAT - 1);
                    n_ret   = ST_DRAW;
                    n_state = ST_WAIT;
                end
            end
            ST_REDUCE: begin
                o_cmd.seed_red = 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_LOAD;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_LOAD: begin
                o_cmd.load_gen1 = 1'b1;
                n_cnt   = CW'(stlr_pkg::LANE_LAT - 1);
                n_ret   = ST_INIT_A;
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (r_cnt == '0) begin
                    n_state = r_ret;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_INIT_A: begin
                o_cmd.step_one     = 1'b1;
                o_cmd.two_from_one = 1'b1;
                n_cnt   = CW'(stlr_pkg::LANE_LAT - 1);
                n_ret   = ST_INIT_B;
                n_state = ST_WAIT;
            end
            ST_INIT_B: begin
                o_cmd.step_one       = 1'b1;
                o_cmd.three_from_one = 1'b1;
                n_fill  = '0;
                n_cnt   = CW'(stlr_pkg::LANE_LAT - 1);
                n_ret   = ST_FILL;
                n_state = ST_WAIT;
            end
            ST_FILL: begin
                o_cmd.step_one = 1'b1;
                o_cmd.step_two = 1'b1;
                o_cmd.fill_we  = 1'b1;
                n_cnt   = CW'(stlr_pkg::LANE_LAT - 1);
                n_state = ST_WAIT;
                if (r_fill == stlr_pkg::TAB_AW'(stlr_pkg::TABLE_DEPTH - 1)) begin
                    n_seeded = 1'b1;
                    n_ret    = ST_DRAW;
                end else begin
                    n_fill = r_fill + 1'b1;
                    n_ret  = ST_FILL;
                end
            end
            ST_DRAW: begin
                o_cmd.step_one   = 1'b1;
                o_cmd.step_two   = 1'b1;
                o_cmd.step_three = 1'b1;
                n_cnt   = CW'(stlr_pkg::LANE_LAT - 1);
                n_ret   = ST_READ;
                n_state = ST_WAIT;
            end
            ST_READ: begin
                o_cmd.read_slot = 1'b1;
                n_state = ST_DELIVER;
            end
            ST_DELIVER: begin
                if (w_out_free) begin
                    o_cmd.deliver = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // hold state, counters and the result flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ret       <= ST_IDLE;
            r_cnt       <= '0;
            r_fill      <= '0;
            r_seeded    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_cnt       <= n_cnt;
            r_fill      <= n_fill;
            r_seeded    <= n_seeded;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/shuffled_triple_lcg_random_core.sv =====
// Top level of the shuffled triple-LCG uniform random generator.
//
//   channel     dir  beat contents                      handshake
//   i_seed_ch   in   seed (s32)                         valid/ready, sink
//   o_draw_ch   out  draw_high, draw_low, seed_out      valid/ready, source
//
// A plain draw runs from accept to result through two waits on the generator lanes
// and the slot unit (each a four-stage multiply pipeline), plus decode, table read
// and hand-off. A reseeding draw replaces the first wait with seed reduction and
// 100 lane steps (seed load, two warm-up steps, 97 table fills), each followed by
// a wait on the lanes.
// Synchronous active-low reset clears the generators and the seeded flag; the table
// is not cleared. A new seed is taken while a finished draw waits in the output
// register; a draw is only held back if the previous one has not been taken yet.
module shuffled_triple_lcg_random_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    stlr_stream_if.sink   i_seed_ch,
    stlr_stream_if.source o_draw_ch
);

    stlr_pkg::t_cmd       w_cmd;
    stlr_pkg::t_sts       w_sts;
    stlr_pkg::t_seed_beat w_seed;
    stlr_pkg::t_draw_beat w_draw;

    assign w_seed = i_seed_ch.payload;

    stlr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_seed_ch.valid),
        .o_in_ready  (i_seed_ch.ready),
        .o_out_valid (o_draw_ch.valid),
        .i_out_ready (o_draw_ch.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    stlr_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_seed  (w_seed),
        .o_draw  (w_draw)
    );

    assign o_draw_ch.payload = w_draw;

endmodule

// ===== bench/tb_shuffled_triple_lcg_random_core.sv =====
// Testbench for the shuffled triple-LCG core: every draw beat checked against a local predictor.
module tb_shuffled_triple_lcg_random_core;

    // Predicts each draw from the accepted seeds and checks the beats that come back
    class draw_scoreboard;
        logic [17:0]           lcg_one;
        logic [17:0]           lcg_two;
        logic [17:0]           lcg_three;
        logic [35:0]           pair_table [stlr_pkg::TABLE_DEPTH];
        bit                    seeded;
        stlr_pkg::t_draw_beat  draws_due [$];
        int unsigned           mismatches;

        function new();
            lcg_one    = '0;
            lcg_two    = '0;
            lcg_three  = '0;
            seeded     = 1'b0;
            mismatches = 0;
            foreach (pair_table[i]) pair_table[i] = '0;
        endfunction

        function logic [17:0] lcg_next(input logic [17:0] x, input logic [17:0] a,
                                       input logic [17:0] c, input logic [17:0] m);
            return 18'((64'(x) * 64'(a) + 64'(c)) % 64'(m));
        endfunction

        function void advance_one();
            lcg_one = lcg_next(lcg_one, stlr_pkg::A_ONE, stlr_pkg::C_ONE, stlr_pkg::M_ONE);
        endfunction

        function void advance_two();
            lcg_two = lcg_next(lcg_two, stlr_pkg::A_TWO, stlr_pkg::C_TWO, stlr_pkg::M_TWO);
        endfunction

        // Work out the draw caused by one accepted seed beat and queue it
        function void note_seed(input stlr_pkg::t_seed_beat b);
            longint               s;
            longint               r;
            int unsigned          slot;
            logic [35:0]          held;
            stlr_pkg::t_draw_beat d;
            s = b.seed;
            d.seed_out = b.seed;
            // Reseed on a negative seed or on the first request after reset
            if (s < 0 || !seeded) begin
                r = (longint'(stlr_pkg::C_ONE) - s) % longint'(stlr_pkg::M_ONE);
                if (r < 0) r += longint'(stlr_pkg::M_ONE);
                lcg_one = 18'(r);
                advance_one();
                lcg_two = lcg_one % stlr_pkg::M_TWO;
                advance_one();
                lcg_three = lcg_one % stlr_pkg::M_THREE;
                for (int i = 0; i < stlr_pkg::TABLE_DEPTH; i++) begin
                    advance_one();
                    advance_two();
                    pair_table[i] = {lcg_one, lcg_two};
                end
                seeded     = 1'b1;
                d.seed_out = 32'sd1;
            end
            // Advance all three generators, then swap the picked slot
            advance_one();
            advance_two();
            lcg_three = lcg_next(lcg_three, stlr_pkg::A_THREE, stlr_pkg::C_THREE,
                                 stlr_pkg::M_THREE);
            slot = int'((64'(lcg_three) * 64'(stlr_pkg::TABLE_DEPTH))
                        / 64'(stlr_pkg::M_THREE));
            if (slot >= stlr_pkg::TABLE_DEPTH) slot = stlr_pkg::TABLE_DEPTH - 1;
            held = pair_table[slot];
            pair_table[slot] = {lcg_one, lcg_two};
            d.draw_high = held[35:18];
            d.draw_low  = held[17:0];
            draws_due.push_back(d);
        endfunction

        // Compare one accepted draw beat with the oldest expected draw
        function void check_draw(input stlr_pkg::t_draw_beat got);
            stlr_pkg::t_draw_beat want;
            if (draws_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected draw: high %0d low %0d seed_out %0d",
                             got.draw_high, got.draw_low, got.seed_out);
                return;
            end
            want = draws_due.pop_front();
            if (got.draw_high !== want.draw_high || got.draw_low !== want.draw_low ||
                got.seed_out !== want.seed_out) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("draw mismatch: want %0d/%0d/%0d got %0d/%0d/%0d",
                             want.draw_high, want.draw_low, want.seed_out,
                             got.draw_high, got.draw_low, got.seed_out);
            end
        endfunction

        function int unsigned pending();
            return draws_due.size();
        endfunction
    endclass

    localparam int RANDOM_ITEMS = 1600;

    logic i_clk;
    logic i_rst_n;

    stlr_stream_if #(.t_payload(stlr_pkg::t_seed_beat)) seed_ch ();
    stlr_stream_if #(.t_payload(stlr_pkg::t_draw_beat)) draw_ch ();

    draw_scoreboard sb = new();
    int unsigned    draws_taken = 0;

    shuffled_triple_lcg_random_core u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_seed_ch (seed_ch),
        .o_draw_ch (draw_ch)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watch both channels and feed the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (draw_ch.valid && draw_ch.ready) begin
                sb.check_draw(draw_ch.payload);
                draws_taken <= draws_taken + 1;
            end
            if (seed_ch.valid && seed_ch.ready)
                sb.note_seed(seed_ch.payload);
        end
    end

    // Draw receiver: random stalls, one long hold-off, one stretch always ready
    initial begin
        int unsigned hold_left;
        bit          held_once;
        hold_left = 0;
        held_once = 1'b0;
        draw_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held_once && draws_taken >= 150) begin
                held_once = 1'b1;
                hold_left = 400;
            end
            if (!i_rst_n) begin
                draw_ch.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left--;
                draw_ch.ready <= 1'b0;
            end else if (draws_taken >= 600 && draws_taken < 900) begin
                draw_ch.ready <= 1'b1;
            end else begin
                draw_ch.ready <= ($urandom_range(0, 99) >= 14);
            end
        end
    end

    // Offer one seed beat and hold it until accepted
    task automatic offer_seed(input logic signed [31:0] s);
        seed_ch.valid   <= 1'b1;
        seed_ch.payload <= stlr_pkg::t_seed_beat'(s);
        do @(posedge i_clk); while (!(seed_ch.valid && seed_ch.ready));
    endtask

    // Drop valid for one cycle
    task automatic idle_seed_side();
        seed_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly plain draws, a few reseeds from random negatives, some extremes
    function automatic logic signed [31:0] pick_seed();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 7)
            return signed'({1'b1, 31'($urandom)});
        if (roll < 9) begin
            case ($urandom_range(0, 4))
                0:       return -32'sd2147483648;
                1:       return -32'sd1;
                2:       return 32'sd0;
                3:       return -32'sd204327;
                default: return 32'sd54773;
            endcase
        end
        return 32'($urandom_range(0, 54773));
    endfunction

    // Main stimulus
    initial begin
        logic signed [31:0] directed [$];
        bit                 calm;
        i_rst_n         <= 1'b0;
        seed_ch.valid   <= 1'b0;
        seed_ch.payload <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // First request seeds the block even though the seed is positive
        directed = '{32'sd54773, 32'sd54773, 32'sd0, 32'sd1, 32'sd21845, 32'sd10922,
                     -32'sd1, 32'sd12345, -32'sd2147483648, 32'sd54773,
                     -32'sd204327, 32'sd0, 32'shAAAAAAAA, 32'shD5555555,
                     -32'sd259100, -32'sd54773, 32'sd40000, 32'sd7};
        foreach (directed[i]) begin
            if ($urandom_range(0, 99) < 14) idle_seed_side();
            offer_seed(directed[i]);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 600 && n < 900);
            // Pause once until every expected draw is back
            if (n == 1100) begin
                do idle_seed_side(); while (sb.pending() != 0);
                repeat ($urandom_range(1, 20)) idle_seed_side();
            end
            while (!calm && $urandom_range(0, 99) < 14) idle_seed_side();
            offer_seed(pick_seed());
        end
        seed_ch.valid <= 1'b0;

        // Drain, then allow for a full reseed's worth of cycles
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb_shuffled_triple_lcg_random_core passed");
        end else begin
            $display("tb_shuffled_triple_lcg_random_core failed");
        end
        $finish;
    end

    // Run limit
    initial begin
        #50000000;
        $display("tb_shuffled_triple_lcg_random_core failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/stlr_pkg.sv
rtl/core/stlr_stream_if.sv
rtl/core/stlr_lcg.sv
rtl/core/stlr_slot.sv
rtl/core/stlr_datapath.sv
rtl/core/stlr_ctrl.sv
rtl/core/shuffled_triple_lcg_random_core.sv
bench/tb_shuffled_triple_lcg_random_core.sv
